// ===== hdl/wmrg_pkg.sv =====
// wmrg_pkg: shared constants, types and state codes for the windowed median range gate
// no dependencies; imported by every module of the block

package wmrg_pkg;

   // default sizing of the top level
   localparam int BEACONS_DEF       = 8;
   localparam int HISTORY_DEPTH_DEF = 16;
   localparam int RANGE_BITS_DEF    = 24;

   // fixed field widths
   localparam int BEACON_IDX_W = 3;
   localparam int TS_W         = 63;
   localparam int SAMPLE_W     = 24;
   localparam int COUNT_W      = 5;
   localparam int MEDIAN_W     = 25;
   localparam int WINDOW_W     = 32;
   localparam int THRESH_W     = 24;
   localparam int MINHIST_W    = 5;

   // stream payload layout
   localparam int REQ_TDATA_W    = 96;
   localparam int REQ_BEACON_LSB = 0;
   localparam int REQ_TS_LSB     = REQ_BEACON_LSB + BEACON_IDX_W;
   localparam int REQ_RANGE_LSB  = REQ_TS_LSB + TS_W;

   localparam int RSP_TDATA_W      = 40;
   localparam int RSP_ACCEPTED_BIT = 0;
   localparam int RSP_GOOD_BIT     = 1;
   localparam int RSP_COUNT_LSB    = 2;
   localparam int RSP_MEDIAN_LSB   = RSP_COUNT_LSB + COUNT_W;
   localparam int RSP_EMPTY_BIT    = RSP_MEDIAN_LSB + MEDIAN_W;
   localparam int RSP_PAD_W        = RSP_TDATA_W - RSP_EMPTY_BIT - 1;

   // register port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_HISTORY = 2'd2;

   localparam logic [WINDOW_W-1:0]  WINDOW_RST  = 32'd10000000;
   localparam logic [THRESH_W-1:0]  THRESH_RST  = 24'd1000;
   localparam logic [MINHIST_W-1:0] MINHIST_RST = 5'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PRUNE_RD,
      ST_PRUNE_CHK,
      ST_SORT,
      ST_PICK_LO,
      ST_PICK_HI,
      ST_GATE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic clear;
      logic insert;
   } sort_ctl_type;

endpackage

// ===== hdl/windowed_median_range_gate.sv =====
// windowed_median_range_gate: per-beacon sliding-window median outlier gate for range samples
// depends on wmrg_pkg and wmrg_sorter; history lives in two ring-buffer memories
//
//  channel  | direction | handshake           | contents
//  req_     | in        | tvalid/tready       | beacon index, timestamp, range sample
//  rsp_     | out       | tvalid/tready       | accepted, good, count, median x2, empty
//  csr_     | in        | we (no wait)        | index 0 window, 1 threshold, 2 min history
//
// one transaction at a time: take it, read and age-check the oldest entry, dropping entries
// until a check keeps one, stream the remaining ranges through the sorter, read the two
// middle ranks, gate, then move the result into rsp; when pruning empties the history the
// age check, sort and rank reads are skipped; a bad beacon index goes straight to done
// synchronous reset clears head/fill pointers and control registers; memories need no clearing
// a stalled rsp_ holds the next result in the done state until the output register frees

module windowed_median_range_gate #(
   parameter int BEACONS       = wmrg_pkg::BEACONS_DEF,
   parameter int HISTORY_DEPTH = wmrg_pkg::HISTORY_DEPTH_DEF,
   parameter int RANGE_BITS    = wmrg_pkg::RANGE_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // beacon_index[2:0], timestamp_us[65:3], range_sample[89:66], zero pad
   input  logic [wmrg_pkg::REQ_TDATA_W-1:0] req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // accepted[0], good[1], history_count[6:2], median_doubled[31:7],
   // history_was_empty[32], zero pad
   output logic [wmrg_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                             csr_we,
   input  logic [wmrg_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [wmrg_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import wmrg_pkg::*;

   localparam int BEACON_W = (BEACONS > 1) ? $clog2(BEACONS) : 1;
   localparam int POS_W    = $clog2(HISTORY_DEPTH);
   localparam int FILL_W   = $clog2(HISTORY_DEPTH + 1);
   localparam int ADDR_W   = $clog2(BEACONS * HISTORY_DEPTH);
   localparam int ENTRIES  = BEACONS * HISTORY_DEPTH;
   localparam int SUM_W    = RANGE_BITS + 1;
   localparam int CMP_W    = (SUM_W > THRESH_W + 1) ? SUM_W : THRESH_W + 1;
   localparam int GOOD_W   = (FILL_W > MINHIST_W) ? FILL_W : MINHIST_W;

   function automatic logic [POS_W-1:0] pos_inc(input logic [POS_W-1:0] p);
      return (p == POS_W'(HISTORY_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [POS_W-1:0] pos_add(input logic [POS_W-1:0] p,
                                                input logic [FILL_W-1:0] f);
      logic [POS_W:0] s;
      s = {1'b0, p} + (POS_W + 1)'(f);
      if (s >= (POS_W + 1)'(HISTORY_DEPTH)) begin
         s = s - (POS_W + 1)'(HISTORY_DEPTH);
      end
      return s[POS_W-1:0];
   endfunction

   function automatic logic [ADDR_W-1:0] slot_addr(input logic [BEACON_W-1:0] b,
                                                   input logic [POS_W-1:0] p);
      return ADDR_W'(b) * ADDR_W'(HISTORY_DEPTH) + ADDR_W'(p);
   endfunction

   // control and configuration
   state_type             state_ff, state_in;
   logic [WINDOW_W-1:0]   window_ff, window_in;
   logic [THRESH_W-1:0]   thresh_ff, thresh_in;
   logic [MINHIST_W-1:0]  min_hist_ff, min_hist_in;
   logic [POS_W-1:0]      head_ff [BEACONS];
   logic [POS_W-1:0]      head_in [BEACONS];
   logic [FILL_W-1:0]     fill_ff [BEACONS];
   logic [FILL_W-1:0]     fill_in [BEACONS];

   // transaction in flight
   logic [BEACON_W-1:0]   beacon_ff, beacon_in;
   logic [TS_W-1:0]       ts_ff, ts_in;
   logic [RANGE_BITS-1:0] rs_ff, rs_in;
   logic [POS_W-1:0]      cur_head_ff, cur_head_in;
   logic [FILL_W-1:0]     cur_fill_ff, cur_fill_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [FILL_W-1:0]     issue_ff, issue_in;
   logic                  rd_vld_ff, rd_vld_in;
   logic [RANGE_BITS-1:0] lo_ff, lo_in;
   logic [SUM_W-1:0]      medd_ff, medd_in;

   // result
   logic                  res_accepted_ff, res_accepted_in;
   logic                  res_good_ff, res_good_in;
   logic [COUNT_W-1:0]    res_count_ff, res_count_in;
   logic [MEDIAN_W-1:0]   res_median_ff, res_median_in;
   logic                  res_empty_ff, res_empty_in;
   logic                  rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_TDATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;

   // history memories
   logic [TS_W-1:0]       time_mem  [ENTRIES];
   logic [RANGE_BITS-1:0] range_mem [ENTRIES];
   logic [TS_W-1:0]       rd_time_ff;
   logic [RANGE_BITS-1:0] rd_range_ff;
   logic [ADDR_W-1:0]     rd_addr;
   logic [ADDR_W-1:0]     wr_addr;
   logic                  mem_we;

   // decoded request and helpers
   logic [BEACON_IDX_W-1:0] req_beacon;
   logic [TS_W-1:0]         req_ts;
   logic [SAMPLE_W-1:0]     req_range;
   logic [31:0]             beacon_ext;
   logic [BEACON_W-1:0]     beacon_sel;
   logic                    beacon_ok;
   logic [RANGE_BITS-1:0]   rs_masked;
   logic                    drop_entry;
   logic                    rsp_free;

   // sorter
   sort_ctl_type          sort_ctl;
   logic [POS_W-1:0]      pick_idx;
   logic [RANGE_BITS-1:0] pick_data;

   // gate datapath
   logic                  hist_empty;
   logic                  hist_full;
   logic [CMP_W-1:0]      s2_ext;
   logic [CMP_W-1:0]      medd_ext;
   logic [CMP_W-1:0]      diff;
   logic [CMP_W-1:0]      thr2;
   logic                  gate_accept;
   logic [POS_W-1:0]      base_head;
   logic [FILL_W-1:0]     base_fill;
   logic [FILL_W-1:0]     new_fill;

   assign req_beacon = req_tdata[REQ_BEACON_LSB +: BEACON_IDX_W];
   assign req_ts     = req_tdata[REQ_TS_LSB +: TS_W];
   assign req_range  = req_tdata[REQ_RANGE_LSB +: SAMPLE_W];
   assign beacon_ext = 32'(req_beacon);
   assign beacon_sel = beacon_ext[BEACON_W-1:0];
   assign beacon_ok  = (beacon_ext < 32'(BEACONS));
   assign rsp_free   = !rsp_tvalid_ff || rsp_tready;

   always_comb begin
      rs_masked = '0;
      for (int i = 0; i < RANGE_BITS; i++) begin
         if (i < SAMPLE_W) begin
            rs_masked[i] = req_range[i];
         end
      end
   end

   // an entry goes only when the sample is later by strictly more than the window
   assign drop_entry = (ts_ff > rd_time_ff) && ((ts_ff - rd_time_ff) > TS_W'(window_ff));

   assign rd_addr = slot_addr(beacon_ff, (state_ff == ST_SORT) ? pos_ff : cur_head_ff);

   // gate arithmetic, all at doubled scale
   assign hist_empty  = (cur_fill_ff == '0);
   assign hist_full   = (cur_fill_ff == FILL_W'(HISTORY_DEPTH));
   assign s2_ext      = CMP_W'({rs_ff, 1'b0});
   assign medd_ext    = CMP_W'(medd_ff);
   assign diff        = (s2_ext >= medd_ext) ? (s2_ext - medd_ext) : (medd_ext - s2_ext);
   assign thr2        = CMP_W'({thresh_ff, 1'b0});
   assign gate_accept = hist_empty || !(diff > thr2);
   assign base_head   = hist_full ? pos_inc(cur_head_ff) : cur_head_ff;
   assign base_fill   = hist_full ? FILL_W'(HISTORY_DEPTH - 1) : cur_fill_ff;
   assign new_fill    = gate_accept ? base_fill + 1'b1 : cur_fill_ff;
   assign wr_addr     = slot_addr(beacon_ff, pos_add(base_head, base_fill));

   wmrg_sorter #(
      .DEPTH  (HISTORY_DEPTH),
      .DATA_W (RANGE_BITS)
   ) u_sorter (
      .clock    (clock),
      .reset    (reset),
      .ctl      (sort_ctl),
      .ins_data (rd_range_ff),
      .rd_idx   (pick_idx),
      .rd_data  (pick_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = beacon_ok ? ST_PRUNE_RD : ST_DONE;
            end
         end
         ST_PRUNE_RD: begin
            state_in = (cur_fill_ff == '0) ? ST_GATE : ST_PRUNE_CHK;
         end
         ST_PRUNE_CHK: begin
            state_in = drop_entry ? ST_PRUNE_RD : ST_SORT;
         end
         ST_SORT: begin
            if ((issue_ff == cur_fill_ff) && !rd_vld_ff) begin
               state_in = ST_PICK_LO;
            end
         end
         ST_PICK_LO: state_in = ST_PICK_HI;
         ST_PICK_HI: state_in = ST_GATE;
         ST_GATE:    state_in = ST_DONE;
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      window_in       = window_ff;
      thresh_in       = thresh_ff;
      min_hist_in     = min_hist_ff;
      head_in         = head_ff;
      fill_in         = fill_ff;
      beacon_in       = beacon_ff;
      ts_in           = ts_ff;
      rs_in           = rs_ff;
      cur_head_in     = cur_head_ff;
      cur_fill_in     = cur_fill_ff;
      pos_in          = pos_ff;
      issue_in        = issue_ff;
      rd_vld_in       = 1'b0;
      lo_in           = lo_ff;
      medd_in         = medd_ff;
      res_accepted_in = res_accepted_ff;
      res_good_in     = res_good_ff;
      res_count_in    = res_count_ff;
      res_median_in   = res_median_ff;
      res_empty_in    = res_empty_ff;
      sort_ctl        = '0;
      pick_idx        = '0;
      mem_we          = 1'b0;

      if (csr_we) begin
         unique case (csr_index)
            CSR_WINDOW:      window_in   = csr_wdata[WINDOW_W-1:0];
            CSR_THRESHOLD:   thresh_in   = csr_wdata[THRESH_W-1:0];
            CSR_MIN_HISTORY: min_hist_in = csr_wdata[MINHIST_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               beacon_in       = beacon_sel;
               ts_in           = req_ts;
               rs_in           = rs_masked;
               res_accepted_in = 1'b0;
               res_good_in     = 1'b0;
               res_count_in    = '0;
               res_median_in   = '0;
               res_empty_in    = 1'b0;
               if (beacon_ok) begin
                  cur_head_in = head_ff[beacon_sel];
                  cur_fill_in = fill_ff[beacon_sel];
               end
            end
         end
         ST_PRUNE_RD: ;
         ST_PRUNE_CHK: begin
            if (drop_entry) begin
               cur_head_in = pos_inc(cur_head_ff);
               cur_fill_in = cur_fill_ff - 1'b1;
            end else begin
               sort_ctl.clear = 1'b1;
               pos_in         = cur_head_ff;
               issue_in       = '0;
            end
         end
         ST_SORT: begin
            // read issued this cycle lands in rd_range_ff and enters the sorter next cycle
            if (issue_ff != cur_fill_ff) begin
               issue_in  = issue_ff + 1'b1;
               pos_in    = pos_inc(pos_ff);
               rd_vld_in = 1'b1;
            end
            sort_ctl.insert = rd_vld_ff;
         end
         ST_PICK_LO: begin
            pick_idx = POS_W'((cur_fill_ff - 1'b1) >> 1);
            lo_in    = pick_data;
         end
         ST_PICK_HI: begin
            pick_idx = POS_W'(cur_fill_ff >> 1);
            medd_in  = SUM_W'(lo_ff) + SUM_W'(pick_data);
         end
         ST_GATE: begin
            // pruning sticks even when the sample is rejected
            head_in[beacon_ff] = gate_accept ? base_head : cur_head_ff;
            fill_in[beacon_ff] = new_fill;
            mem_we             = gate_accept;
            res_accepted_in    = gate_accept;
            res_good_in        = gate_accept && (GOOD_W'(new_fill) > GOOD_W'(min_hist_ff));
            res_count_in       = COUNT_W'(new_fill);
            res_median_in      = hist_empty ? '0 : MEDIAN_W'(medd_ff);
            res_empty_in       = hist_empty;
         end
         ST_DONE: ;
         default: ;
      endcase
   end

   // output register
   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      if ((state_ff == ST_DONE) && rsp_free) begin
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in  = {{RSP_PAD_W{1'b0}}, res_empty_ff, res_median_ff, res_count_ff,
                          res_good_ff, res_accepted_ff};
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         window_ff     <= WINDOW_RST;
         thresh_ff     <= THRESH_RST;
         min_hist_ff   <= MINHIST_RST;
         rsp_tvalid_ff <= 1'b0;
         rd_vld_ff     <= 1'b0;
         for (int b = 0; b < BEACONS; b++) begin
            head_ff[b] <= '0;
            fill_ff[b] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         window_ff     <= window_in;
         thresh_ff     <= thresh_in;
         min_hist_ff   <= min_hist_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         rd_vld_ff     <= rd_vld_in;
         head_ff       <= head_in;
         fill_ff       <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      beacon_ff       <= beacon_in;
      ts_ff           <= ts_in;
      rs_ff           <= rs_in;
      cur_head_ff     <= cur_head_in;
      cur_fill_ff     <= cur_fill_in;
      pos_ff          <= pos_in;
      issue_ff        <= issue_in;
      lo_ff           <= lo_in;
      medd_ff         <= medd_in;
      res_accepted_ff <= res_accepted_in;
      res_good_ff     <= res_good_in;
      res_count_ff    <= res_count_in;
      res_median_ff   <= res_median_in;
      res_empty_ff    <= res_empty_in;
      rsp_tdata_ff    <= rsp_tdata_in;
   end

   // history memories: one write port, one registered read port each
   always_ff @(posedge clock) begin
      if (mem_we) begin
         time_mem[wr_addr]  <= ts_ff;
         range_mem[wr_addr] <= rs_ff;
      end
      rd_time_ff  <= time_mem[rd_addr];
      rd_range_ff <= range_mem[rd_addr];
   end

endmodule

// ===== hdl/wmrg_sorter.sv =====
// wmrg_sorter: insertion sorter that keeps the ranges of one history in ascending order
// one value enters per cycle while insert is high; any rank can be read out; depends on wmrg_pkg

module wmrg_sorter #(
   parameter int  DEPTH  = wmrg_pkg::HISTORY_DEPTH_DEF,
   parameter int  DATA_W = wmrg_pkg::RANGE_BITS_DEF,
   localparam int IDX_W  = $clog2(DEPTH)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  wmrg_pkg::sort_ctl_type ctl,
   input  logic [DATA_W-1:0]     ins_data,
   input  logic [IDX_W-1:0]      rd_idx,
   output logic [DATA_W-1:0]     rd_data
);
   import wmrg_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] slot_ff [DEPTH];
   logic [DATA_W-1:0] slot_in [DEPTH];
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic [DEPTH-1:0]  keep;

   // keep marks the sorted prefix that stays put; the rest shifts up by one
   always_comb begin
      for (int j = 0; j < DEPTH; j++) begin
         keep[j] = (CNT_W'(j) < count_ff) && (slot_ff[j] <= ins_data);
      end
      slot_in[0] = keep[0] ? slot_ff[0] : ins_data;
      for (int j = 1; j < DEPTH; j++) begin
         if (keep[j]) begin
            slot_in[j] = slot_ff[j];
         end else if (keep[j-1]) begin
            slot_in[j] = ins_data;
         end else begin
            slot_in[j] = slot_ff[j-1];
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      priority if (ctl.clear) begin
         count_in = '0;
      end else if (ctl.insert) begin
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.insert) begin
         for (int j = 0; j < DEPTH; j++) begin
            slot_ff[j] <= slot_in[j];
         end
      end
   end

   assign rd_data = slot_ff[rd_idx];

endmodule

// ===== hdl/wmrg_checker.sv =====
// wmrg_checker: port-level assertions for the windowed median range gate
// depends on wmrg_pkg; bound to windowed_median_range_gate at the end of this file

module wmrg_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [wmrg_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import wmrg_pkg::*;

   logic                accepted;
   logic                good;
   logic                empty;
   logic [COUNT_W-1:0]  count;
   logic [MEDIAN_W-1:0] median;

   assign accepted = rsp_tdata[RSP_ACCEPTED_BIT];
   assign good     = rsp_tdata[RSP_GOOD_BIT];
   assign empty    = rsp_tdata[RSP_EMPTY_BIT];
   assign count    = rsp_tdata[RSP_COUNT_LSB +: COUNT_W];
   assign median   = rsp_tdata[RSP_MEDIAN_LSB +: MEDIAN_W];

   // a stalled result holds
   rsp_hold_a: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp transaction changed while stalled");

   // one transaction at a time: busy right after taking one
   req_busy_a: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req taken again before the previous transaction finished");

   // an empty history always takes the sample and reports no median
   empty_take_a: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && empty |-> accepted && (median == '0))
      else $error("empty history result not accepted or median nonzero");

   good_accept_a: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && good |-> accepted)
      else $error("good flag without acceptance");

   // a stored sample leaves at least one entry
   accept_count_a: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && accepted |-> (count != '0))
      else $error("accepted sample with empty history count");

endmodule

bind windowed_median_range_gate wmrg_checker u_wmrg_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
